[rtl/cbs_pkg.sv]
// Package for the cubic B-spline SPH kernel unit: word types, widths,
// opcodes, register indexes and the normalization table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cbs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int POLY_BITS     = 30;
  localparam int RQ_W          = 31;
  localparam int NORM_W        = 31;
  localparam int WIDE_W        = 92;
  localparam int OUT_SHIFT     = 28;
  localparam int RES_W         = 64;
  localparam int MAX_STEPS     = 5;
  localparam int STEP_W        = 3;
  localparam int RECIP_SHIFT   = 33;

  localparam logic [1:0]        DIM_RESET      = 2'd3;
  localparam logic [DATA_W-1:0] LENGTH_RESET   = 32'd65536;
  localparam logic [RQ_W-1:0]   TWO_THIRDS_Q30 = 31'd715827883;
  localparam logic [DATA_W-1:0] THIRD_RECIP    = 32'hAAAAAAAB;
  localparam logic [RES_W-1:0]  POS_MAX        = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0]  NEG_MIN        = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_VALUE = 2'd0,
    OP_SLOPE = 2'd1,
    OP_CURVE = 2'd2
  } op_t;

  typedef enum logic {
    CFG_DIMENSION = 1'b0,
    CFG_LENGTH    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] distance;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] kernel_result;
    logic                    length_error;
    logic                    saturated;
  } out_word_t;

  typedef struct packed {
    logic [1:0] op;
    logic       neg_r;
    logic       inner;
    logic       kill;
    logic       len_err;
  } rq_side_t;

  typedef struct packed {
    logic              neg;
    logic              kill;
    logic              len_err;
    logic [STEP_W-1:0] steps;
    logic              sat;
  } scale_side_t;

  localparam int RQ_SW = $bits(rq_side_t);
  localparam int SC_SW = $bits(scale_side_t);

  function automatic logic [NORM_W-1:0] norm_q30(input logic [1:0] dim);
    logic [NORM_W-1:0] v;
    unique case (dim)
      2'd0: v = '0;
      2'd1: v = 31'd1073741824;
      2'd2: v = 31'd732391367;
      2'd3: v = 31'd512673957;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/cbs_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage,
// with a side word that travels alongside. Depends on cbs_pkg.
`default_nettype none

module cbs_div_pipe #(
  parameter int QW = cbs_pkg::RQ_W,
  parameter int SW = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [cbs_pkg::DATA_W-1:0] in_rem,
  input  logic [QW-1:0]              in_low,
  input  logic                       in_bypass,
  input  logic [SW-1:0]              in_side,
  input  logic [cbs_pkg::DATA_W-1:0] divisor,
  input  logic [cbs_pkg::DATA_W-1:0] bypass_divisor,
  output logic                       out_valid,
  output logic [QW-1:0]              out_quo,
  output logic [SW-1:0]              out_side
);
  import cbs_pkg::*;

  logic              vld_q    [QW];
  logic [DATA_W-1:0] rem_q    [QW];
  logic [QW-1:0]     bits_q   [QW];
  logic              byp_q    [QW];
  logic [SW-1:0]     side_q   [QW];

  logic              vld_src  [QW];
  logic [DATA_W-1:0] rem_src  [QW];
  logic [QW-1:0]     bits_src [QW];
  logic              byp_src  [QW];
  logic [SW-1:0]     side_src [QW];
  logic [DATA_W:0]   dsel     [QW];
  logic [DATA_W:0]   trial    [QW];
  logic              take     [QW];

  // The remainder stays below the divisor; the quotient bits shift in at the bottom
  // while the dividend bits shift out at the top.
  always_comb begin
    vld_src[0]  = in_valid;
    rem_src[0]  = in_rem;
    bits_src[0] = in_low;
    byp_src[0]  = in_bypass;
    side_src[0] = in_side;
    for (int k = 1; k < QW; k++) begin
      vld_src[k]  = vld_q[k-1];
      rem_src[k]  = rem_q[k-1];
      bits_src[k] = bits_q[k-1];
      byp_src[k]  = byp_q[k-1];
      side_src[k] = side_q[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      dsel[k]  = {1'b0, byp_src[k] ? bypass_divisor : divisor};
      trial[k] = {rem_src[k], bits_src[k][QW-1]};
      take[k]  = trial[k] >= dsel[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < QW; k++) begin
        vld_q[k] <= vld_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k]  <= take[k] ? DATA_W'(trial[k] - dsel[k]) : trial[k][DATA_W-1:0];
        bits_q[k] <= {bits_src[k][QW-2:0], take[k]};
        byp_q[k]  <= byp_src[k];
        side_q[k] <= side_src[k];
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign out_quo   = bits_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

[rtl/cubic_bspline_sph_kernel_unit.sv]
// Top level of the cubic B-spline SPH kernel unit: configuration registers,
// polynomial stages, scaling dividers and output buffer. Depends on cbs_pkg, cbs_div_pipe.
// It takes one word per cycle unless the output buffer is full; one result per input word.
`default_nettype none

// The unit accepts one input word in every cycle while the output buffer has room and
// returns each result in the order its word was accepted. The path runs through the
// 31-stage divider that forms R = |r|/h and through five 92-stage dividers that
// apply the 1/h scaling, one quotient bit per stage, with the six multiply and polynomial
// stages in between. A two-word output buffer lets the pipeline keep moving
// while a result waits; when both entries are full the whole pipeline holds.
// Configuration may be written only while no word is in flight.

module cubic_bspline_sph_kernel_unit #(
  parameter int FRAC_BITS = cbs_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  cbs_pkg::cfg_idx_t          cfg_index,
  input  logic [cbs_pkg::DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cbs_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cbs_pkg::out_word_t         out_word
);
  import cbs_pkg::*;

  localparam int                P_W        = 35;
  localparam logic [DATA_W-1:0] BYPASS_DIV = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [P_W-1:0]    TWO_Q30    = P_W'(64'd1 << (POLY_BITS + 1));

  logic [1:0]        dimension;
  logic [DATA_W-1:0] smoothing_length;
  logic              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension        <= DIM_RESET;
      smoothing_length <= LENGTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DIMENSION) begin
        dimension <= cfg_data[1:0];
      end else begin
        smoothing_length <= cfg_data;
      end
    end
  end

  // Input register: magnitude and sign of the distance.
  logic              s0_valid;
  logic [1:0]        s0_op;
  logic              s0_neg;
  logic [DATA_W-1:0] s0_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      s0_op  <= in_word.op;
      s0_neg <= in_word.distance[DATA_W-1];
      s0_a   <= in_word.distance[DATA_W-1] ? DATA_W'(-in_word.distance) : in_word.distance;
    end
  end

  rq_side_t          s0_side;
  logic [DATA_W-1:0] s0_rem;
  logic [RQ_W-1:0]   s0_low;

  always_comb begin
    s0_side.op      = s0_op;
    s0_side.neg_r   = s0_neg;
    s0_side.inner   = s0_a < smoothing_length;
    s0_side.len_err = smoothing_length == '0;
    s0_side.kill    = s0_side.len_err
                      || !(s0_op == OP_VALUE || s0_op == OP_SLOPE || s0_op == OP_CURVE)
                      || ({1'b0, s0_a} >= {smoothing_length, 1'b0});
    s0_rem = s0_side.kill ? '0 : {1'b0, s0_a[DATA_W-1:1]};
    s0_low = s0_side.kill ? '0 : {s0_a[0], {POLY_BITS{1'b0}}};
  end

  logic              rq_valid;
  logic [RQ_W-1:0]   rq;
  logic [RQ_SW-1:0]  rq_side_bits;
  rq_side_t          rq_side;

  cbs_div_pipe #(
    .QW (RQ_W),
    .SW (RQ_SW)
  ) u_rq_div (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s0_valid),
    .in_rem         (s0_rem),
    .in_low         (s0_low),
    .in_bypass      (1'b0),
    .in_side        (s0_side),
    .divisor        (smoothing_length),
    .bypass_divisor (BYPASS_DIV),
    .out_valid      (rq_valid),
    .out_quo        (rq),
    .out_side       (rq_side_bits)
  );

  assign rq_side = rq_side_bits;

  // Polynomial stages: u is R inside the unit radius and 2 - R outside it.
  logic              m1_valid, m2_valid, m3_valid, m4_valid, m5_valid, m6_valid;
  rq_side_t          m1_side, m2_side, m3_side, m4_side;
  scale_side_t       m5_side, m6_side;
  logic [RQ_W-1:0]   m1_u, m2_u, m3_u, m4_u;
  logic [RQ_W-1:0]   m2_u2, m3_u2, m4_u2;
  logic [RQ_W-1:0]   m3_u3, m4_u3;
  logic [RQ_W-1:0]   m4_q6;
  logic [DATA_W-1:0] m5_mag;
  logic [WIDE_W-1:0] m6_x;

  logic [2*RQ_W-1:0]     sq_prod, cu_prod;
  logic [2*RQ_W-1:0]     q6_prod;
  logic [DATA_W+NORM_W-1:0] nm_prod;
  logic signed [P_W-1:0] su, su2, su3, sq6, p;
  logic                  p_neg;

  always_comb begin
    sq_prod = m1_u * m1_u;
    cu_prod = m2_u2 * m2_u;
    q6_prod = m3_u3[RQ_W-1:1] * THIRD_RECIP;
    nm_prod = m5_mag * norm_q30(dimension);
    su  = P_W'(m4_u);
    su2 = P_W'(m4_u2);
    su3 = P_W'(m4_u3);
    sq6 = P_W'(m4_q6);
    if (m4_side.inner) begin
      unique case (m4_side.op)
        OP_VALUE: p = P_W'(TWO_THIRDS_Q30) - su2 + (su3 >>> 1);
        OP_SLOPE: p = su2 + (su2 >>> 1) - (su <<< 1);
        OP_CURVE: p = su + (su <<< 1) - TWO_Q30;
        default:  p = '0;
      endcase
    end else begin
      unique case (m4_side.op)
        OP_VALUE: p = sq6;
        OP_SLOPE: p = -(su2 >>> 1);
        OP_CURVE: p = su;
        default:  p = '0;
      endcase
    end
    p_neg = p[P_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      m5_valid <= 1'b0;
      m6_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= rq_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      m5_valid <= m4_valid;
      m6_valid <= m5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side <= rq_side;
      m1_u    <= rq_side.inner ? rq : RQ_W'({1'b1, {RQ_W{1'b0}}} - {1'b0, rq});

      m2_side <= m1_side;
      m2_u    <= m1_u;
      m2_u2   <= sq_prod[POLY_BITS +: RQ_W];

      m3_side <= m2_side;
      m3_u    <= m2_u;
      m3_u2   <= m2_u2;
      m3_u3   <= cu_prod[POLY_BITS +: RQ_W];

      m4_side <= m3_side;
      m4_u    <= m3_u;
      m4_u2   <= m3_u2;
      m4_u3   <= m3_u3;
      m4_q6   <= RQ_W'(q6_prod >> RECIP_SHIFT);

      m5_side.neg     <= p_neg ^ (m4_side.op == OP_SLOPE && m4_side.neg_r);
      m5_side.kill    <= m4_side.kill;
      m5_side.len_err <= m4_side.len_err;
      m5_side.steps   <= STEP_W'(dimension) + STEP_W'(m4_side.op);
      m5_side.sat     <= 1'b0;
      m5_mag          <= p_neg ? DATA_W'(-p) : DATA_W'(p);

      m6_side <= m5_side;
      m6_x    <= WIDE_W'(nm_prod);
    end
  end

  // Scaling chain: each unit multiplies by 2^FRAC_BITS / h when its step is active and
  // otherwise by one, passing the word through; a word that would overflow passes on as zero, flagged saturated.
  wire              sc_valid [MAX_STEPS+1];
  wire [WIDE_W-1:0] sc_x     [MAX_STEPS+1];
  wire [SC_SW-1:0]  sc_side  [MAX_STEPS+1];

  assign sc_valid[0] = m6_valid;
  assign sc_x[0]     = m6_x;
  assign sc_side[0]  = m6_side;

  for (genvar j = 0; j < MAX_STEPS; j++) begin : g_scale
    scale_side_t       side_in;
    scale_side_t       side_out;
    logic              active;
    logic              sat_now;
    logic [DATA_W-1:0] top_part;
    logic [DATA_W-1:0] div_rem;
    logic [WIDE_W-1:0] div_low;

    always_comb begin
      side_in      = sc_side[j];
      top_part     = DATA_W'(sc_x[j] >> (WIDE_W - FRAC_BITS));
      active       = STEP_W'(j) < side_in.steps;
      sat_now      = side_in.sat || (active && (top_part >= smoothing_length));
      side_out     = side_in;
      side_out.sat = sat_now;
      div_rem      = sat_now ? '0 : top_part;
      div_low      = sat_now ? '0 : WIDE_W'(sc_x[j] << FRAC_BITS);
    end

    cbs_div_pipe #(
      .QW (WIDE_W),
      .SW (SC_SW)
    ) u_scale_div (
      .clk            (clk),
      .rst            (rst),
      .en             (en),
      .in_valid       (sc_valid[j]),
      .in_rem         (div_rem),
      .in_low         (div_low),
      .in_bypass      (!active || sat_now),
      .in_side        (side_out),
      .divisor        (smoothing_length),
      .bypass_divisor (BYPASS_DIV),
      .out_valid      (sc_valid[j+1]),
      .out_quo        (sc_x[j+1]),
      .out_side       (sc_side[j+1])
    );
  end

  scale_side_t      fin_side;
  logic [RES_W-1:0] fin_mag;
  logic             fin_over;
  out_word_t        fin_word;

  always_comb begin
    fin_side = sc_side[MAX_STEPS];
    fin_mag  = sc_x[MAX_STEPS][WIDE_W-1:OUT_SHIFT];
    fin_over = fin_side.sat || (fin_side.neg ? (fin_mag > NEG_MIN) : (fin_mag > POS_MAX));
    if (fin_side.kill) begin
      fin_word.kernel_result = '0;
      fin_word.length_error  = fin_side.len_err;
      fin_word.saturated     = 1'b0;
    end else if (fin_over) begin
      fin_word.kernel_result = fin_side.neg ? NEG_MIN : POS_MAX;
      fin_word.length_error  = 1'b0;
      fin_word.saturated     = 1'b1;
    end else begin
      fin_word.kernel_result = fin_side.neg ? RES_W'(-fin_mag) : fin_mag;
      fin_word.length_error  = 1'b0;
      fin_word.saturated     = 1'b0;
    end
  end

  // Two-word output buffer.
  logic      [1:0] ob_count, ob_count_next;
  out_word_t       ob_head, ob_spare;
  logic            push, pop;

  assign en        = ob_count != 2'd2;
  assign in_ready  = en;
  assign push      = sc_valid[MAX_STEPS] && en;
  assign out_valid = ob_count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_word  = ob_head;

  always_comb begin
    ob_count_next = ob_count + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= 2'd0;
    end else begin
      ob_count <= ob_count_next;
    end
  end

  always_ff @(posedge clk) begin
    priority if (ob_count == 2'd0 || (ob_count == 2'd1 && pop)) begin
      if (push) begin
        ob_head <= fin_word;
      end
    end else if (ob_count == 2'd1) begin
      if (push) begin
        ob_spare <= fin_word;
      end
    end else if (pop) begin
      ob_head <= ob_spare;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.length_error |-> out_word.kernel_result == '0 && !out_word.saturated)
    else $error("Length error word carries a nonzero result or a saturation flag.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.saturated |->
      out_word.kernel_result == POS_MAX || out_word.kernel_result == NEG_MIN)
    else $error("Saturated word does not hold a range limit.");

  assert property (@(posedge clk) disable iff (rst)
    ob_count == 2'd2 |=> ob_count != 2'd0)
    else $error("Output buffer dropped two words in one cycle.");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Pipeline stalled with an empty output buffer.");

endmodule

`default_nettype wire

[tb/tb_cubic_bspline_sph_kernel_unit.sv]
// Self-checking testbench for cubic_bspline_sph_kernel_unit: directed probe table, then
// random distances under several dimension and smoothing length settings.
// Depends on cbs_pkg and the unit's RTL; results come from a local predictor or the table.
`timescale 1ns / 1ps

module tb_cubic_bspline_sph_kernel_unit;
  import cbs_pkg::*;

  localparam int          FRAC          = FRAC_BITS_DEF;
  localparam logic [1:0]  OP_UNDEF      = 2'd3;
  localparam logic [31:0] LEN_ONE       = 32'd65536;
  localparam logic [31:0] LEN_MAX       = 32'hFFFF_FFFF;
  localparam int          PROBE_COUNT   = 25;
  localparam int          RAND_PHASES   = 9;
  localparam int          PHASE_ITEMS   = 45;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 600;

  localparam out_word_t RES_ZERO    = {64'd0, 1'b0, 1'b0};
  localparam out_word_t RES_LEN_ERR = {64'd0, 1'b1, 1'b0};
  localparam out_word_t RES_POS_SAT = {POS_MAX, 1'b0, 1'b1};
  localparam out_word_t RES_NEG_SAT = {NEG_MIN, 1'b0, 1'b1};

  typedef struct packed {
    logic [1:0]  dim;
    logic [31:0] len;
    logic [1:0]  op;
    logic [31:0] distance;
    logic        known;
    out_word_t   res;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  cfg_idx_t    cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  out_word_t   expected_kernel_q[$];
  int          fault_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  logic [1:0]  cur_dim = 2'd3;
  logic [31:0] cur_len = LEN_ONE;

  cubic_bspline_sph_kernel_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL cubic_bspline_sph_kernel_unit");
    $finish;
  end

  function automatic out_word_t spline_kernel(input logic [1:0] op, input logic [31:0] distance,
                                              input logic [1:0] dim, input logic [31:0] len);
    out_word_t    res;
    logic [63:0]  h;
    logic [63:0]  a;
    logic [63:0]  rq;
    logic [63:0]  r2;
    logic [63:0]  r3;
    logic [63:0]  t;
    logic [63:0]  p;
    logic [63:0]  magp;
    logic [63:0]  norm;
    logic [63:0]  mag;
    logic [127:0] wide;
    logic         neg;
    logic         sat;
    int           steps;
    res = RES_ZERO;
    h = {32'b0, len};
    a = distance[31] ? (64'h1_0000_0000 - {32'b0, distance}) : {32'b0, distance};
    if (len == 32'd0) begin
      return RES_LEN_ERR;
    end
    if (op == OP_UNDEF || a >= (h << 1)) begin
      return res;
    end
    rq = (a << POLY_BITS) / h;
    if (a < h) begin
      r2 = (rq * rq) >> POLY_BITS;
      r3 = (r2 * rq) >> POLY_BITS;
      case (op)
        OP_VALUE: p = {33'b0, TWO_THIRDS_Q30} - r2 + (r3 >> 1);
        OP_SLOPE: p = r2 + (r2 >> 1) - (rq << 1);
        default:  p = 64'd3 * rq - (64'd1 << 31);
      endcase
    end else begin
      t = (64'd1 << 31) - rq;
      r2 = (t * t) >> POLY_BITS;
      r3 = (r2 * t) >> POLY_BITS;
      case (op)
        OP_VALUE: p = r3 / 64'd6;
        OP_SLOPE: p = 64'd0 - (r2 >> 1);
        default:  p = t;
      endcase
    end
    neg = p[63];
    magp = neg ? 64'd0 - p : p;
    if (op == OP_SLOPE && distance[31]) begin
      neg = ~neg;
    end
    case (dim)
      2'd1:    norm = 64'd1073741824;
      2'd2:    norm = 64'd732391367;
      2'd3:    norm = 64'd512673957;
      default: norm = 64'd0;
    endcase
    wide = {64'b0, magp * norm};
    steps = int'(dim) + int'(op);
    sat = 1'b0;
    for (int i = 0; i < steps && !sat; i++) begin
      wide = (wide << FRAC) / {96'b0, len};
      if (wide >= (128'd1 << 92)) begin
        sat = 1'b1;
      end
    end
    mag = wide[91:28];
    if (!sat && (neg ? (mag > NEG_MIN) : (mag > POS_MAX))) begin
      sat = 1'b1;
    end
    if (sat) begin
      res.kernel_result = neg ? NEG_MIN : POS_MAX;
      res.saturated = 1'b1;
    end else begin
      res.kernel_result = neg ? 64'd0 - mag : mag;
    end
    return res;
  endfunction

  function automatic probe_t probe(input logic [1:0] dim, input logic [31:0] len,
                                   input logic [1:0] op, input logic [31:0] distance,
                                   input logic known, input out_word_t res);
    probe_t p;
    p.dim = dim;
    p.len = len;
    p.op = op;
    p.distance = distance;
    p.known = known;
    p.res = res;
    return p;
  endfunction

  function automatic probe_t directed_probe(input int idx);
    case (idx)
      0:  return probe(2'd3, LEN_ONE, OP_VALUE, 32'd0, 1'b0, RES_ZERO);
      1:  return probe(2'd3, LEN_ONE, OP_SLOPE, 32'd0, 1'b0, RES_ZERO);
      2:  return probe(2'd3, LEN_ONE, OP_CURVE, 32'd0, 1'b0, RES_ZERO);
      3:  return probe(2'd3, LEN_ONE, OP_VALUE, 32'd32768, 1'b0, RES_ZERO);
      4:  return probe(2'd3, LEN_ONE, OP_SLOPE, -32'd32768, 1'b0, RES_ZERO);
      5:  return probe(2'd3, LEN_ONE, OP_CURVE, 32'd65535, 1'b0, RES_ZERO);
      6:  return probe(2'd3, LEN_ONE, OP_VALUE, 32'd65536, 1'b0, RES_ZERO);
      7:  return probe(2'd3, LEN_ONE, OP_SLOPE, -32'd98304, 1'b0, RES_ZERO);
      8:  return probe(2'd3, LEN_ONE, OP_SLOPE, 32'd98304, 1'b0, RES_ZERO);
      9:  return probe(2'd3, LEN_ONE, OP_CURVE, 32'd131071, 1'b0, RES_ZERO);
      10: return probe(2'd3, LEN_ONE, OP_VALUE, 32'd131072, 1'b1, RES_ZERO);
      11: return probe(2'd3, LEN_ONE, OP_CURVE, -32'd131072, 1'b1, RES_ZERO);
      12: return probe(2'd3, LEN_ONE, OP_UNDEF, 32'd0, 1'b1, RES_ZERO);
      13: return probe(2'd3, LEN_ONE, OP_VALUE, 32'h7FFF_FFFF, 1'b1, RES_ZERO);
      14: return probe(2'd3, LEN_ONE, OP_SLOPE, 32'h8000_0000, 1'b1, RES_ZERO);
      15: return probe(2'd1, LEN_ONE, OP_VALUE, 32'd16384, 1'b0, RES_ZERO);
      16: return probe(2'd2, LEN_ONE, OP_SLOPE, -32'd81920, 1'b0, RES_ZERO);
      17: return probe(2'd0, LEN_ONE, OP_VALUE, 32'd0, 1'b1, RES_ZERO);
      18: return probe(2'd3, 32'd0, OP_VALUE, 32'd0, 1'b1, RES_LEN_ERR);
      19: return probe(2'd3, 32'd0, OP_UNDEF, 32'h8000_0000, 1'b1, RES_LEN_ERR);
      20: return probe(2'd3, 32'd1, OP_CURVE, 32'd0, 1'b1, RES_NEG_SAT);
      21: return probe(2'd3, 32'd1, OP_VALUE, 32'd0, 1'b1, RES_POS_SAT);
      22: return probe(2'd1, LEN_MAX, OP_VALUE, 32'h7FFF_FFFF, 1'b0, RES_ZERO);
      23: return probe(2'd2, LEN_MAX, OP_SLOPE, 32'h8000_0000, 1'b0, RES_ZERO);
      default: return probe(2'd3, LEN_MAX, OP_CURVE, 32'hFFFF_FFFF, 1'b0, RES_ZERO);
    endcase
  endfunction

  task automatic pick_phase(input int ph, output logic [1:0] dim, output logic [31:0] len);
    case (ph)
      0: begin dim = 2'd1; len = LEN_ONE; end
      1: begin dim = 2'd2; len = 32'd98304; end
      2: begin dim = 2'd3; len = 32'd1; end
      3: begin dim = 2'd0; len = LEN_ONE; end
      4: begin dim = 2'd3; len = 32'd0; end
      5: begin dim = 2'd2; len = LEN_MAX; end
      6: begin dim = 2'd1; len = 32'd16; end
      7: begin dim = 2'd3; len = $urandom >> $urandom_range(0, 31); end
      default: begin dim = 2'd2; len = 32'd40000; end
    endcase
  endtask

  function automatic logic [1:0] pick_op();
    if ($urandom_range(0, 11) == 0) begin
      return OP_UNDEF;
    end
    return 2'($urandom_range(0, 2));
  endfunction

  // Mostly distances inside the support of the current smoothing length, some at its
  // piece boundaries, the rest anywhere in the 32-bit range.
  function automatic logic [31:0] pick_distance(input logic [31:0] len);
    logic [63:0] span;
    logic [63:0] mag;
    logic        sign;
    int          mode;
    mode = $urandom_range(0, 9);
    span = {31'b0, len, 1'b0};
    if (mode < 2 || len == 32'd0) begin
      return $urandom;
    end
    if (mode < 4) begin
      case ($urandom_range(0, 3))
        0:       mag = {32'b0, len} - 64'd1;
        1:       mag = {32'b0, len};
        2:       mag = span - 64'd1;
        default: mag = span;
      endcase
    end else begin
      mag = {$urandom, $urandom} % span;
    end
    if (mag > 64'h8000_0000) begin
      mag = mag & 64'h7FFF_FFFF;
    end
    sign = 1'($urandom_range(0, 1));
    if (mag == 64'h8000_0000) begin
      sign = 1'b1;
    end
    mag = sign ? 64'd0 - mag : mag;
    return mag[31:0];
  endfunction

  task automatic sender_gap();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(input in_word_t w, input out_word_t want);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_kernel_q.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_kernel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] dim, input logic [31:0] len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DIMENSION;
    cfg_data <= {30'b0, dim};
    @(posedge clk);
    cfg_index <= CFG_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_dim = dim;
    cur_len = len;
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_kernel_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected word: expected none, actual %h/%b/%b", $time,
                 out_word.kernel_result, out_word.length_error, out_word.saturated);
      end else begin
        want = expected_kernel_q.pop_front();
        if (out_word !== want) begin
          fault_count++;
          $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b", $time,
                   want.kernel_result, want.length_error, want.saturated,
                   out_word.kernel_result, out_word.length_error, out_word.saturated);
        end
      end
    end
  end

  initial begin
    probe_t     row;
    in_word_t   w;
    logic [1:0] dim;
    logic [31:0] len;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_DIMENSION;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PROBE_COUNT; i++) begin
      row = directed_probe(i);
      if (row.dim != cur_dim || row.len != cur_len) begin
        drain_results();
        write_config(row.dim, row.len);
      end
      sender_gap();
      w.op = row.op;
      w.distance = row.distance;
      send_word(w, row.known ? row.res : spline_kernel(row.op, row.distance, cur_dim, cur_len));
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick_phase(ph, dim, len);
      drain_results();
      idle_on = (ph != RAND_PHASES - 1);
      write_config(dim, len);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The sender holds off here until the pipeline has emptied.
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          drain_results();
        end
        sender_gap();
        w.op = pick_op();
        w.distance = pick_distance(cur_len);
        send_word(w, spline_kernel(w.op, w.distance, cur_dim, cur_len));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS cubic_bspline_sph_kernel_unit");
    end else begin
      $display("FAIL cubic_bspline_sph_kernel_unit");
    end
    $finish;
  end

endmodule
